>>> hdl/slap_pkg.sv
// ----------------------------------------------------------------------------
// slap_pkg: shared definitions for the sine LFO auto panner
// Reset values of the control registers, register indexes, the controller
// states and the geometry of the digit-serial multiplier.
// ----------------------------------------------------------------------------
package slap_pkg;

    // Defaults for the top-level parameters.
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int SINE_DEPTH_DEF   = 256;

    // Control register indexes.
    localparam logic [1:0] CFG_PHASE_INC = 2'd0;
    localparam logic [1:0] CFG_DEPTH     = 2'd1;
    localparam logic [1:0] CFG_GAIN      = 2'd2;

    // Control register reset values.
    localparam logic [31:0] PHASE_INC_RST = 32'd17896;
    localparam logic [15:0] DEPTH_RST     = 16'd32768;
    localparam logic [15:0] GAIN_RST      = 16'd16384;

    // Quarter-wave table generation: pi/2 in Q2.30 and the full-scale sine.
    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [63:0] SINE_AMPL   = 64'sd32767;

    // Multiplier geometry: an 18-bit signed operand taken 6 bits per cycle.
    localparam int SER_W   = 18;
    localparam int DIG_W   = 6;
    localparam int NUM_DIG = SER_W / DIG_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INDEX,
        ST_SINE,
        ST_DEPTH,
        ST_MIX,
        ST_LEFT,
        ST_RIGHT,
        ST_FLUSH
    } slap_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } slap_mul_stat_t;

endpackage

>>> hdl/slap_dsmul.sv
// ----------------------------------------------------------------------------
// slap_dsmul: digit-serial signed multiplier
// Multiplies a parallel operand by an 18-bit signed operand that is shifted
// in one 6-bit digit per cycle, least significant digit first.
// ----------------------------------------------------------------------------
module slap_dsmul #(
    parameter int PAR_WIDTH = 17
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      start,
    input  logic [slap_pkg::SER_W-1:0]                ser_op,
    input  logic signed [PAR_WIDTH-1:0]               par_op,
    output slap_pkg::slap_mul_stat_t                  stat,
    output logic signed [PAR_WIDTH+slap_pkg::SER_W-1:0] product
);

    localparam int DW = slap_pkg::DIG_W;
    localparam int SW = slap_pkg::SER_W;
    localparam int ND = slap_pkg::NUM_DIG;
    localparam int HW = PAR_WIDTH + DW + 1;
    localparam int CW = (ND > 1) ? $clog2(ND) : 1;

    logic                 busy_reg;
    logic                 done_reg;
    logic [CW-1:0]        cnt_reg;
    logic [SW-1:0]        ser_reg;
    logic signed [PAR_WIDTH-1:0] par_reg;
    logic signed [HW-1:0] hi_reg;
    logic [SW-1:0]        lo_reg;

    logic                 last_digit;
    logic signed [DW:0]   digit;
    logic signed [HW-1:0] part_prod;
    logic signed [HW-1:0] acc_sum;

    // The top digit carries the sign of the serial operand.
    assign last_digit = (cnt_reg == CW'(ND - 1));
    assign digit      = last_digit ? {ser_reg[DW-1], ser_reg[DW-1:0]}
                                   : {1'b0, ser_reg[DW-1:0]};
    assign part_prod  = par_reg * digit;
    assign acc_sum    = hi_reg + part_prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CW'(1);
            if (last_digit) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    // Low product bits retire into lo_reg as each digit completes.
    always_ff @(posedge aclk) begin
        if (start) begin
            hi_reg  <= '0;
            par_reg <= par_op;
            ser_reg <= ser_op;
        end else if (busy_reg) begin
            hi_reg  <= acc_sum >>> DW;
            lo_reg  <= {acc_sum[DW-1:0], lo_reg[SW-1:DW]};
            ser_reg <= ser_reg >> DW;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = {hi_reg[PAR_WIDTH-1:0], lo_reg};

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("multiplier did not start");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(busy_reg) && !busy_reg)
        else $error("multiplier done without a run");

endmodule

>>> hdl/slap_sine.sv
// ----------------------------------------------------------------------------
// slap_sine: LFO phase accumulator and quarter-wave sine lookup
// Captures the table index from the phase on each request, advances the
// phase, and returns the signed Q1.15 sine from the index and sine registers.
// ----------------------------------------------------------------------------
module slap_sine #(
    parameter int SINE_TABLE_DEPTH = slap_pkg::SINE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [31:0]        phase_inc,
    input  logic               step,
    output logic signed [15:0] sine
);

    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PRW = 30 + IW;

    // Taylor series of sin to the x^13 term in Q30, scaled to Q1.15.
    function automatic logic [14:0] sine_entry(input int k);
        logic [63:0]        th;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] e;
        th   = (slap_pkg::HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
        term = th;
        sum  = signed'(th);
        for (int i = 1; i <= 6; i++) begin
            term = (term * th) >> 30;
            term = (term * th) >> 30;
            term = term / 64'((2 * i) * (2 * i + 1));
            if ((i & 1) == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        e = '0;
        if (sum > 0) begin
            e = (sum * slap_pkg::SINE_AMPL + (64'sd1 <<< 29)) >>> 30;
        end
        if (e > slap_pkg::SINE_AMPL) begin
            e = slap_pkg::SINE_AMPL;
        end
        return e[14:0];
    endfunction

    logic [14:0] sine_rom [0:SINE_TABLE_DEPTH];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
        assign sine_rom[k] = sine_entry(k);
    end

    logic [31:0]  phase_reg;
    logic [IW-1:0] idx_reg;
    logic [1:0]   quad_reg;
    logic signed [15:0] sine_reg;

    logic [PRW-1:0] idx_prod;
    logic [IW-1:0]  rom_addr;
    logic [14:0]    mag;

    assign idx_prod = PRW'(phase_reg[29:0]) * PRW'(SINE_TABLE_DEPTH);
    assign rom_addr = quad_reg[0] ? (IW'(SINE_TABLE_DEPTH) - idx_reg) : idx_reg;
    assign mag      = sine_rom[rom_addr];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_reg + phase_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            idx_reg  <= idx_prod[PRW-1:30];
            quad_reg <= phase_reg[31:30];
        end
        sine_reg <= quad_reg[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    assign sine = sine_reg;

endmodule

>>> hdl/sine_lfo_auto_panner.sv
// ----------------------------------------------------------------------------
// sine_lfo_auto_panner: sine LFO auto panner, mono in, stereo out
// Each accepted mono sample x gives one stereo pair: left is
// gain*(1+depth*sin)*x and right is gain*(1-depth*sin)*x, both rounded and
// saturated to the sample width. A 32-bit phase accumulator, cleared by
// reset, drives a quarter-wave sine table and advances by phase_increment
// once per accepted sample, so the first sample after reset sees a sine of
// zero. From acceptance until its pair is loaded into the result register,
// a sample goes through the sine lookup in the LFO, then four passes through
// a single digit-serial multiplier (depth times sine, the modulation times
// x, and the gain for each channel), each pass fed in 6-bit digits, and then
// the load of the result. The sequencer then returns to idle; no new sample
// is taken until the previous pair has been loaded, and the load is held
// while the pair before it still waits for m_ready. s_ready is high only
// between samples, while the previous pair may still wait in the result
// register for m_ready. Control registers are written through the cfg port
// (cfg_ready is always high) and should only be written while no sample is
// in flight.
// ----------------------------------------------------------------------------
module sine_lfo_auto_panner #(
    parameter int SAMPLE_WIDTH     = slap_pkg::SAMPLE_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH = slap_pkg::SINE_DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Mono input requests.
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [SAMPLE_WIDTH-1:0] s_sample_in,
    // Stereo result requests.
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [SAMPLE_WIDTH-1:0] m_left_out,
    output logic [SAMPLE_WIDTH-1:0] m_right_out,
    // Control register writes.
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_data
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int SER = slap_pkg::SER_W;
    // Parallel multiplier operand must hold the sine, x and the scaled x.
    localparam int PW  = (SAMPLE_WIDTH + 2 > 17) ? SAMPLE_WIDTH + 2 : 17;
    localparam int MW  = PW + SER;
    localparam int RW  = MW - 14;

    localparam logic signed [RW-1:0] Y_MAX =
        RW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] Y_MIN =
        RW'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));
    localparam logic signed [MW:0] HALF_LSB = (MW + 1)'(16384);

    // Round a Q15-scaled product to the nearest integer, halves upward.
    function automatic logic signed [RW-1:0] rnd_q15(input logic signed [MW-1:0] v);
        logic signed [MW:0] w;
        w = {v[MW-1], v} + HALF_LSB;
        return w[MW:15];
    endfunction

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    logic [31:0] phase_inc_reg;
    logic [15:0] depth_reg;
    logic [15:0] gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_inc_reg <= slap_pkg::PHASE_INC_RST;
            depth_reg     <= slap_pkg::DEPTH_RST;
            gain_reg      <= slap_pkg::GAIN_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                slap_pkg::CFG_PHASE_INC: phase_inc_reg <= cfg_data;
                slap_pkg::CFG_DEPTH:     depth_reg     <= cfg_data[15:0];
                slap_pkg::CFG_GAIN:      gain_reg      <= cfg_data[15:0];
                default: ; // Unused index: the write is dropped.
            endcase
        end
    end

    // ------------------------------------------------------------------
    // LFO and multiplier
    // ------------------------------------------------------------------
    logic                s_accept;
    logic signed [15:0]  sine;
    logic                mul_start;
    logic [SER-1:0]      mul_ser;
    logic signed [PW-1:0] mul_par;
    slap_pkg::slap_mul_stat_t mul_stat;
    logic signed [MW-1:0] mul_prod;

    assign s_accept = s_valid && s_ready;

    slap_sine #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_sine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .phase_inc(phase_inc_reg),
        .step     (s_accept),
        .sine     (sine)
    );

    slap_dsmul #(
        .PAR_WIDTH(PW)
    ) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .ser_op (mul_ser),
        .par_op (mul_par),
        .stat   (mul_stat),
        .product(mul_prod)
    );

    // ------------------------------------------------------------------
    // Datapath between passes
    // ------------------------------------------------------------------
    logic signed [SW-1:0] x_reg;
    logic signed [PW-1:0] t_right_reg;
    logic [SW-1:0]        y_left_reg;
    logic [SW-1:0]        y_right_reg;

    logic signed [RW-1:0] rnd_prod;
    logic signed [MW:0]   x_scaled;
    logic signed [MW:0]   t_left_full;
    logic signed [MW:0]   t_right_full;
    logic signed [PW-1:0] t_left;
    logic signed [PW-1:0] t_right;
    logic [SW-1:0]        y_sat;
    logic signed [PW-1:0] x_ext;
    logic signed [PW-1:0] sine_ext;
    logic [SER-1:0]       depth_ser;
    logic [SER-1:0]       gain_ser;

    assign rnd_prod  = rnd_q15(mul_prod);
    assign x_ext     = {{(PW - SW){x_reg[SW-1]}}, x_reg};
    assign sine_ext  = {{(PW - 16){sine[15]}}, sine};
    assign depth_ser = {{(SER - 16){1'b0}}, depth_reg};
    assign gain_ser  = {{(SER - 16){1'b0}}, gain_reg};

    // With m = depth*sine rounded, (1 +/- m) * x rounds to x*2^15 +/- m*x,
    // so both channel amplitudes come from the single product m*x.
    assign x_scaled     = {{(MW + 1 - SW - 15){x_reg[SW-1]}}, x_reg, 15'b0};
    assign t_left_full  = {mul_prod[MW-1], mul_prod} + x_scaled + HALF_LSB;
    assign t_right_full = x_scaled + HALF_LSB - {mul_prod[MW-1], mul_prod};
    assign t_left       = t_left_full[PW+14:15];
    assign t_right      = t_right_full[PW+14:15];

    always_comb begin
        if (rnd_prod > Y_MAX) begin
            y_sat = Y_MAX[SW-1:0];
        end else if (rnd_prod < Y_MIN) begin
            y_sat = Y_MIN[SW-1:0];
        end else begin
            y_sat = rnd_prod[SW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    slap_pkg::slap_state_t state_reg;
    slap_pkg::slap_state_t state_next;
    logic                  out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= slap_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mul_start  = 1'b0;
        mul_ser    = gain_ser;
        mul_par    = t_right_reg;
        out_load   = 1'b0;
        case (state_reg)
            slap_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = slap_pkg::ST_INDEX;
                end
            end
            slap_pkg::ST_INDEX: begin
                // Table read is in flight inside the LFO.
                state_next = slap_pkg::ST_SINE;
            end
            slap_pkg::ST_SINE: begin
                mul_start  = 1'b1;
                mul_ser    = depth_ser;
                mul_par    = sine_ext;
                state_next = slap_pkg::ST_DEPTH;
            end
            slap_pkg::ST_DEPTH: begin
                if (mul_stat.done) begin
                    mul_start  = 1'b1;
                    mul_ser    = rnd_prod[SER-1:0];
                    mul_par    = x_ext;
                    state_next = slap_pkg::ST_MIX;
                end
            end
            slap_pkg::ST_MIX: begin
                if (mul_stat.done) begin
                    mul_start  = 1'b1;
                    mul_ser    = gain_ser;
                    mul_par    = t_left;
                    state_next = slap_pkg::ST_LEFT;
                end
            end
            slap_pkg::ST_LEFT: begin
                if (mul_stat.done) begin
                    mul_start  = 1'b1;
                    mul_ser    = gain_ser;
                    mul_par    = t_right_reg;
                    state_next = slap_pkg::ST_RIGHT;
                end
            end
            slap_pkg::ST_RIGHT: begin
                if (mul_stat.done) begin
                    state_next = slap_pkg::ST_FLUSH;
                end
            end
            slap_pkg::ST_FLUSH: begin
                if (!m_valid || m_ready) begin
                    out_load   = 1'b1;
                    state_next = slap_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = slap_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x_reg <= s_sample_in;
        end
        if (state_reg == slap_pkg::ST_MIX && mul_stat.done) begin
            t_right_reg <= t_right;
        end
        if (state_reg == slap_pkg::ST_LEFT && mul_stat.done) begin
            y_left_reg <= y_sat;
        end
        if (state_reg == slap_pkg::ST_RIGHT && mul_stat.done) begin
            y_right_reg <= y_sat;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                 m_valid_reg;
    logic [SW-1:0]        m_left_reg;
    logic [SW-1:0]        m_right_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_left_reg  <= y_left_reg;
            m_right_reg <= y_right_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_left_out  = m_left_reg;
    assign m_right_out = m_right_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("second sample accepted while one is in flight");

    a_mul_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier restarted while busy");

    a_load_from_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == slap_pkg::ST_FLUSH))
        else $error("result loaded outside the flush state");

endmodule
